>>> src/iirtf_pkg.sv
// Shared types and fixed-point constants for the transposed-form IIR filter.
package iirtf_pkg;

  // Field widths fixed by the item format.
  localparam int OP_W        = 2;
  localparam int COEF_IDX_W  = 5;
  localparam int TAP_COUNT_W = 6;

  // Datapath widths: delays and feedback output are 64 bits, products up to 128.
  localparam int Z_W       = 64;
  localparam int MAG_W     = 64;
  localparam int DIG_W     = 32;
  localparam int ACC_W     = 128;
  localparam int COEF_FRAC = 28;

  localparam logic [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
  localparam logic [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};

  // Operation codes carried by an input word.
  typedef enum logic [OP_W-1:0] {
    OP_FILTER = 2'd0,
    OP_WR_NUM = 2'd1,
    OP_WR_DEN = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COEF_WR,
    ST_LOAD,
    ST_MUL,
    ST_MUL_END,
    ST_Y_SAT,
    ST_TAP_LOAD,
    ST_FOLD,
    ST_TAP_SAT,
    ST_ROUND
  } state_t;

  // Which product the shared multiplier is working on.
  typedef enum logic [1:0] {
    PH_Y,
    PH_FB,
    PH_FF
  } phase_t;

endpackage

>>> src/iir_filter_transposed_form.sv
// IIR filter in transposed direct form II with coefficient and delay memories.
//
// Input channel (in_valid / in_stall): each word carries an operation. A filter
// operation takes one sample and returns one output word; a numerator or
// denominator write stores one coefficient; a clear zeroes the delay line.
// Writes and clears return nothing. Output channel (out_valid / out_stall)
// carries the rounded, saturated sample and a saturation flag.
// The tap count register is written through cfg_we / cfg_data; the user must
// write it only while idle, which the block itself does not enforce. A
// coefficient write is a read-modify-write of the shared coefficient entry.
// A sample is worked by a single 32x32 multiplier that builds each product
// from four partial products: one product for the first tap and two for each
// further tap, with one read of each memory per tap.
// The output register holds a finished word while the receiver stalls; the
// next word is taken meanwhile, and a sample waits in its last step only when
// the previous result has still not been taken.
// Reset sets the tap count to one, drops every coefficient and delay (they
// read as zero until written) and empties the output register.
module iir_filter_transposed_form #(
  parameter int MAX_TAPS     = 32,
  parameter int SAMPLE_WIDTH = 32,
  parameter int COEF_WIDTH   = 44
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [iirtf_pkg::TAP_COUNT_W-1:0]      cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [iirtf_pkg::OP_W-1:0]             operation,
  input  logic [iirtf_pkg::COEF_IDX_W-1:0]       coef_index,
  input  logic signed [COEF_WIDTH-1:0]           coef_value,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]         filtered_sample,
  output logic                                   saturated
);

  import iirtf_pkg::*;

  localparam int DLY_DEPTH = MAX_TAPS - 1;
  localparam int CA_W      = $clog2(MAX_TAPS);
  localparam int DA_W      = (DLY_DEPTH > 1) ? $clog2(DLY_DEPTH) : 1;
  localparam int TW        = $clog2(MAX_TAPS + 1);
  localparam int CW        = COEF_WIDTH;
  localparam int SW        = SAMPLE_WIDTH;

  // Two's complement magnitude of a 64-bit value.
  function automatic logic [MAG_W-1:0] magnitude(input logic [MAG_W-1:0] v);
    magnitude = v[MAG_W-1] ? ((~v) + MAG_W'(1)) : v;
  endfunction

  // Control state.
  state_t              state;
  state_t              state_next;
  phase_t              phase;
  logic [TAP_COUNT_W-1:0] tap_count;
  logic [MAX_TAPS-1:0] coef_vld;
  logic [DLY_DEPTH-1:0] dly_vld;
  logic                pp_vld;

  // Datapath registers.
  logic [1:0]          mstep;
  logic [2*DIG_W-1:0]  pp;
  logic [1:0]          pp_shift;
  logic [MAG_W-1:0]    mag_a;
  logic [MAG_W-1:0]    mag_b;
  logic                neg;
  logic [ACC_W-1:0]    acc;
  logic signed [SW-1:0] x;
  logic [Z_W-1:0]      y;
  logic [Z_W-1:0]      zin;
  logic [CW-1:0]       coef_b;
  logic [TW-1:0]       taps;
  logic [TW-1:0]       tap;
  logic                flag;
  logic                coef_rvld;
  logic                dly_rvld;
  op_t                 wr_op;
  logic [CW-1:0]       wr_value;
  logic [CA_W-1:0]     wr_addr;

  // Memory ports.
  logic                coef_we;
  logic [CA_W-1:0]     coef_raddr;
  logic [2*CW-1:0]     coef_wdata;
  logic [2*CW-1:0]     coef_rdata;
  logic                dly_we;
  logic [DA_W-1:0]     dly_waddr;
  logic [DA_W-1:0]     dly_raddr;
  logic [Z_W-1:0]      dly_rdata;

  // Derived values.
  op_t                 op_in;
  logic                coef_in_range;
  logic [TW-1:0]       taps_eff;
  logic [TW-1:0]       tap_inc;
  logic                more_taps;
  logic                use_z;
  logic [CW-1:0]       num_rd;
  logic [CW-1:0]       den_rd;
  logic [MAG_W-1:0]    x_ext;
  logic [DIG_W-1:0]    a_dig;
  logic [DIG_W-1:0]    b_dig;
  logic [2*DIG_W-1:0]  prod;
  logic [ACC_W-1:0]    pp_term;
  logic [ACC_W-1:0]    acc_pp;
  logic [ACC_W-Z_W:0]  sat_hi;
  logic                sat_ovf;
  logic [Z_W-1:0]      sat_val;
  logic [Z_W:0]        rnd_sum;
  logic [Z_W:0]        rnd_shift;
  logic [Z_W-SW+1:0]   rnd_hi;
  logic                rnd_ovf;
  logic [SW-1:0]       rnd_val;

  assign op_in         = op_t'(operation);
  assign coef_in_range = int'(coef_index) < MAX_TAPS;
  assign tap_inc       = tap + TW'(1);
  assign more_taps     = tap_inc < taps;
  assign x_ext         = MAG_W'(x);

  // Tap count as used: zero means a plain gain, large values clamp.
  always_comb begin
    if (tap_count == '0) begin
      taps_eff = TW'(1);
    end else if (int'(tap_count) > MAX_TAPS) begin
      taps_eff = TW'(MAX_TAPS);
    end else begin
      taps_eff = TW'(tap_count);
    end
  end

  // Entries never written since reset read as zero.
  assign num_rd = coef_rvld ? coef_rdata[2*CW-1:CW] : '0;
  assign den_rd = coef_rvld ? coef_rdata[CW-1:0] : '0;
  assign use_z  = dly_rvld && more_taps;

  // Shared multiplier: one 32x32 digit product per step.
  assign a_dig   = mstep[0] ? mag_a[2*DIG_W-1:DIG_W] : mag_a[DIG_W-1:0];
  assign b_dig   = mstep[1] ? mag_b[2*DIG_W-1:DIG_W] : mag_b[DIG_W-1:0];
  assign prod    = (2*DIG_W)'(a_dig) * (2*DIG_W)'(b_dig);
  assign pp_term = ACC_W'(pp) << (DIG_W * pp_shift);
  assign acc_pp  = neg ? (acc - pp_term) : (acc + pp_term);

  // Saturation of the accumulator to a 64-bit delay or feedback value.
  assign sat_hi  = acc[ACC_W-1:Z_W-1];
  assign sat_ovf = !((&sat_hi) || !(|sat_hi));
  assign sat_val = sat_ovf ? (acc[ACC_W-1] ? Z_MIN : Z_MAX) : acc[Z_W-1:0];

  // Output rounding: add one half LSB, drop the extra fraction bits, saturate.
  assign rnd_sum   = {y[Z_W-1], y} + ((Z_W+1)'(1) << (COEF_FRAC - 1));
  assign rnd_shift = $signed(rnd_sum) >>> COEF_FRAC;
  assign rnd_hi    = rnd_shift[Z_W:SW-1];
  assign rnd_ovf   = !((&rnd_hi) || !(|rnd_hi));
  assign rnd_val   = rnd_ovf ? (rnd_shift[Z_W] ? {1'b1, {(SW-1){1'b0}}}
                                               : {1'b0, {(SW-1){1'b1}}})
                             : rnd_shift[SW-1:0];

  // Merged coefficient entry for a write: the other half keeps its value.
  assign coef_wdata = (wr_op == OP_WR_NUM) ? {wr_value, den_rd} : {num_rd, wr_value};
  assign dly_waddr  = DA_W'(tap - TW'(1));

  iirtf_ram #(
    .WIDTH (2*CW),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (wr_addr),
    .wdata (coef_wdata),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  iirtf_ram #(
    .WIDTH (Z_W),
    .DEPTH (DLY_DEPTH)
  ) u_dly_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (dly_waddr),
    .wdata (sat_val),
    .raddr (dly_raddr),
    .rdata (dly_rdata)
  );

  assign in_stall = (state != ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory control.
  always_comb begin
    state_next = state;
    coef_raddr = '0;
    dly_raddr  = '0;
    coef_we    = 1'b0;
    dly_we     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (op_in)
            OP_FILTER: begin
              state_next = ST_LOAD;
            end
            OP_WR_NUM, OP_WR_DEN: begin
              if (coef_in_range) begin
                coef_raddr = CA_W'(coef_index);
                state_next = ST_COEF_WR;
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_COEF_WR: begin
        coef_we    = 1'b1;
        state_next = ST_IDLE;
      end
      ST_LOAD: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mstep == 2'd3) begin
          state_next = ST_MUL_END;
        end
      end
      ST_MUL_END: begin
        case (phase)
          PH_Y:    state_next = ST_Y_SAT;
          PH_FB:   state_next = ST_FOLD;
          default: state_next = ST_TAP_SAT;
        endcase
      end
      ST_Y_SAT: begin
        if (taps > TW'(1)) begin
          coef_raddr = tap[CA_W-1:0];
          dly_raddr  = DA_W'(tap);
          state_next = ST_TAP_LOAD;
        end else begin
          state_next = ST_ROUND;
        end
      end
      ST_TAP_LOAD: begin
        state_next = ST_MUL;
      end
      ST_FOLD: begin
        state_next = ST_MUL;
      end
      ST_TAP_SAT: begin
        dly_we = 1'b1;
        if (more_taps) begin
          coef_raddr = tap_inc[CA_W-1:0];
          dly_raddr  = DA_W'(tap_inc);
          state_next = ST_TAP_LOAD;
        end else begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers: tap count, entry valid bits, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_W'(1);
      coef_vld  <= '0;
      dly_vld   <= '0;
      pp_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        tap_count <= cfg_data;
      end
      pp_vld <= (state == ST_MUL);
      if (state == ST_IDLE && in_valid && op_in == OP_CLEAR) begin
        dly_vld <= '0;
      end
      if (coef_we) begin
        coef_vld[wr_addr] <= 1'b1;
      end
      if (dly_we) begin
        dly_vld[dly_waddr] <= 1'b1;
      end
      if (state == ST_ROUND && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    coef_rvld <= coef_vld[coef_raddr];
    dly_rvld  <= (int'(dly_raddr) < DLY_DEPTH) ? dly_vld[dly_raddr] : 1'b0;
    if (pp_vld) begin
      acc <= acc_pp;
    end
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          x        <= sample;
          taps     <= taps_eff;
          tap      <= TW'(1);
          flag     <= 1'b0;
          wr_op    <= op_in;
          wr_value <= coef_value;
          wr_addr  <= CA_W'(coef_index);
        end
      end
      ST_LOAD: begin
        // y starts from the first delay, then b[0]*x is accumulated.
        mag_a <= magnitude(MAG_W'($signed(num_rd)));
        mag_b <= magnitude(x_ext);
        neg   <= num_rd[CW-1] ^ x[SW-1];
        acc   <= (taps > TW'(1) && dly_rvld) ? ACC_W'($signed(dly_rdata)) : '0;
        phase <= PH_Y;
        mstep <= '0;
      end
      ST_MUL: begin
        pp       <= prod;
        pp_shift <= {1'b0, mstep[0]} + {1'b0, mstep[1]};
        mstep    <= mstep + 2'd1;
      end
      ST_Y_SAT: begin
        y    <= sat_val;
        flag <= flag | sat_ovf;
      end
      ST_TAP_LOAD: begin
        // Feedback product a*y first, on its own, so it can be floored.
        coef_b <= num_rd;
        zin    <= use_z ? dly_rdata : '0;
        mag_a  <= magnitude(MAG_W'($signed(den_rd)));
        mag_b  <= magnitude(y);
        neg    <= den_rd[CW-1] ^ y[Z_W-1];
        acc    <= '0;
        phase  <= PH_FB;
        mstep  <= '0;
      end
      ST_FOLD: begin
        // Next delay minus the floored feedback, then b*x is accumulated.
        acc   <= ACC_W'($signed(zin)) - ($signed(acc) >>> COEF_FRAC);
        mag_a <= magnitude(MAG_W'($signed(coef_b)));
        mag_b <= magnitude(x_ext);
        neg   <= coef_b[CW-1] ^ x[SW-1];
        phase <= PH_FF;
        mstep <= '0;
      end
      ST_TAP_SAT: begin
        flag <= flag | sat_ovf;
        if (more_taps) begin
          tap <= tap_inc;
        end
      end
      ST_ROUND: begin
        if (!out_valid || !out_stall) begin
          filtered_sample <= rnd_val;
          saturated       <= flag | rnd_ovf;
        end
      end
      default: begin
      end
    endcase
  end

  // A new result only comes out of the rounding step.
  a_out_from_round: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_ROUND))
    else $error("output loaded outside the rounding step");

  // A waiting result is never overwritten by the next sample.
  a_round_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && out_valid && out_stall) |=> state == ST_ROUND)
    else $error("rounding step left while the output was still held");

  // Partial products are only folded in while the multiplier runs.
  a_pp_in_mul: assert property (@(posedge clk) disable iff (rst)
    pp_vld |-> (state == ST_MUL || state == ST_MUL_END))
    else $error("partial product added outside a multiply");

  // Delay writes stay within the active taps.
  a_dly_range: assert property (@(posedge clk) disable iff (rst)
    dly_we |-> (tap != '0 && tap < taps))
    else $error("delay write outside the active taps");

  // Each tap step works on a tap that exists.
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAP_LOAD) |-> (tap != '0 && tap < taps && $past(state != ST_IDLE)))
    else $error("tap index out of range");

endmodule

>>> src/iirtf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module iirtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
